/* rtl/stepper_ramp_interval_generator_macros.svh */
// Assertion helpers shared by the ramp generator modules.
`ifndef STEPPER_RAMP_INTERVAL_GENERATOR_MACROS_SVH
`define STEPPER_RAMP_INTERVAL_GENERATOR_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define SRIG_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define SRIG_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/srig_pkg.sv */
`timescale 1ns / 1ps
package srig_pkg;

  localparam int CHANNELS = 4;
  localparam int CH_W     = 2;

  localparam logic [23:0] TIMER_BASE_HZ = 24'd12000000;
  localparam logic [31:0] TGT_NUM       = 32'd720000000;
  localparam logic [16:0] STOP_PAD      = 17'd100;
  localparam logic [10:0] RUNIN_LIMIT   = 11'd1024;
  localparam logic [48:0] M_CAP         = {49{1'b1}};
  localparam logic [31:0] RUNIN_EDGE    = 32'hFFFF0000;
  localparam logic [2:0]  SHIFT_MAX     = 3'd5;

  localparam logic [1:0] MODE_SPEED   = 2'd0;
  localparam logic [1:0] MODE_TICK    = 2'd1;
  localparam logic [1:0] MODE_DISABLE = 2'd2;

  localparam logic [2:0] CFG_SHIFT0 = 3'd0;
  localparam logic [2:0] CFG_SHIFT1 = 3'd1;
  localparam logic [2:0] CFG_SHIFT2 = 3'd2;
  localparam logic [2:0] CFG_SHIFT3 = 3'd3;
  localparam logic [2:0] CFG_ACCEL  = 3'd4;
  localparam logic [2:0] CFG_MAXIV  = 3'd5;

  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    OP_SPEED,
    OP_TICK,
    OP_DISABLE,
    OP_NOP
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [CH_W-1:0]  ch;
    logic [31:0]      spm;
  } item_t;

  typedef struct packed {
    logic [3:0][2:0] shift;
    logic [15:0]     accel;
    logic [15:0]     max_iv;
  } cfg_t;

  typedef struct packed {
    logic [CH_W-1:0] ch;
    logic [15:0]     period;
    logic [14:0]     compare;
    logic            ld;
    logic            stp;
    logic            stopped_ev;
    logic            ok;
  } res_t;

endpackage

/* rtl/srig_front.sv */
`timescale 1ns / 1ps
module srig_front
  import srig_pkg::*;
(
  input  logic            in_valid,
  input  logic [1:0]      in_mode,
  input  logic [CH_W-1:0] in_channel,
  input  logic [31:0]     in_steps_per_minute,
  output logic            in_stall,
  input  logic            q_full,
  output logic            q_push,
  output item_t           q_item
);

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_item.ch  = in_channel;
    q_item.spm = in_steps_per_minute;
    if (int'(in_channel) >= CHANNELS) begin
      q_item.op = OP_NOP;
    end else begin
      unique case (in_mode)
        MODE_SPEED:   q_item.op = OP_SPEED;
        MODE_TICK:    q_item.op = OP_TICK;
        MODE_DISABLE: q_item.op = OP_DISABLE;
        default:      q_item.op = OP_NOP;
      endcase
    end
  end

endmodule

/* rtl/srig_queue.sv */
`timescale 1ns / 1ps
module srig_queue
  import srig_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  q_valid,
  output item_t q_item
);

  `include "stepper_ramp_interval_generator_macros.svh"

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t              mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;

  assign full    = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_item  = mem_r[rd_r];

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wr_nxt = (wr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_nxt = (rd_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_r + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_item;
    end
  end

  `SRIG_ASSERT_IMP(a_q_no_underflow, pop, cnt_r != '0, "queue popped while empty")
  `SRIG_ASSERT_IMP(a_q_no_overflow, push, !full, "queue pushed while full")

endmodule

/* rtl/srig_back.sv */
`timescale 1ns / 1ps
module srig_back
  import srig_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  cfg_t  cfg,
  input  logic  q_valid,
  input  item_t q_item,
  output logic  q_pop,
  output logic  out_valid,
  input  logic  out_stall,
  output res_t  out_res
);

  `include "stepper_ramp_interval_generator_macros.svh"

  typedef enum logic [17:0] {
    S_IDLE    = 18'h00001,
    S_DISP    = 18'h00002,
    S_TDIV    = 18'h00004,
    S_TGT     = 18'h00008,
    S_FF      = 18'h00010,
    S_TA      = 18'h00020,
    S_RAD     = 18'h00040,
    S_SQRT    = 18'h00080,
    S_NUM     = 18'h00100,
    S_DIV     = 18'h00200,
    S_MAG     = 18'h00400,
    S_RUNCHK  = 18'h00800,
    S_RSMUL   = 18'h01000,
    S_RSSH    = 18'h02000,
    S_RSFIN   = 18'h04000,
    S_RUNFIN  = 18'h08000,
    S_TICKFIN = 18'h10000,
    S_COMMIT  = 18'h20000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  res_t   res_r, res_nxt;

  // per-channel state
  logic [15:0] cur_r   [CHANNELS];
  logic [15:0] cur_nxt [CHANNELS];
  logic [15:0] tst_r   [CHANNELS];
  logic [15:0] tst_nxt [CHANNELS];
  logic [31:0] ex_r    [CHANNELS];
  logic [31:0] ex_nxt  [CHANNELS];
  logic [49:0] rc_r    [CHANNELS];
  logic [49:0] rc_nxt  [CHANNELS];

  // working registers
  logic [CH_W-1:0] ch_r, ch_nxt;
  op_t             op_r, op_nxt;
  logic [31:0]     spm_r, spm_nxt;
  logic            dir_r, dir_nxt;
  logic [15:0]     tgt_r, tgt_nxt;
  logic [2:0]      sh_r, sh_nxt;
  logic [15:0]     base_r, base_nxt;
  logic [47:0]     ff_r, ff_nxt;
  logic [31:0]     bb_r, bb_nxt;
  logic [48:0]     ta_r, ta_nxt;
  logic [63:0]     x_r, x_nxt;
  logic [32:0]     rem_r, rem_nxt;
  logic [31:0]     dv_r, dv_nxt;
  logic [63:0]     rt_r, rt_nxt;
  logic [63:0]     bit_r, bit_nxt;
  logic [6:0]      cnt_r, cnt_nxt;
  logic [48:0]     mr_r, mr_nxt;
  logic [48:0]     mq_r, mq_nxt;
  logic            msat_r, msat_nxt;
  logic [49:0]     m_r, m_nxt;
  logic [10:0]     n_r, n_nxt;
  logic [63:0]     c_r, c_nxt;
  logic [63:0]     w_r, w_nxt;
  logic [127:0]    p_r, p_nxt;
  logic [1:0]      pp_r, pp_nxt;
  logic [1:0]      stg_r, stg_nxt;
  logic            ret_tick_r, ret_tick_nxt;
  logic [63:0]     nx_r, nx_nxt;

  // datapath helpers
  logic [23:0]  f_w;
  logic [15:0]  a_w;
  logic [32:0]  div_sh, div_rem;
  logic         div_ge;
  logic [63:0]  sq_trial;
  logic         sq_ge;
  logic         mag_bit, mag_ge, msat_w;
  logic [49:0]  mag_sh, mag_sub;
  logic [48:0]  mq_sh, mag_val;
  logic [49:0]  m_abs;
  logic [63:0]  opa;
  logic [31:0]  mul_a, mul_b;
  logic [63:0]  prod;
  logic [127:0] pp_term;
  logic [63:0]  rs_val;
  logic         rs_sat;
  logic [64:0]  sum65;
  logic [63:0]  nx_pos, nx_neg, tq_w, tick_nx;
  logic         tick_clamp;
  logic [47:0]  ab_w;
  logic [39:0]  num_w;
  logic [49:0]  rad_w;
  logic [31:0]  q_tgt;
  logic [15:0]  t16;
  logic [16:0]  stop_spm;
  logic [2:0]   sh_sel;

  function automatic res_t make_res(input logic [CH_W-1:0] ch, input logic ld,
                                    input logic [15:0] period, input logic stp,
                                    input logic ev, input logic ok);
    res_t r;
    r.ch         = ch;
    r.period     = ld ? period : 16'd0;
    r.compare    = ld ? period[15:1] : 15'd0;
    r.ld         = ld;
    r.stp        = stp;
    r.stopped_ev = ev;
    r.ok         = ok;
    return r;
  endfunction

  assign f_w      = TIMER_BASE_HZ >> sh_r;
  assign a_w      = cfg.accel >> sh_r;
  assign div_sh   = {rem_r[31:0], x_r[63]};
  assign div_ge   = (div_sh >= {1'b0, dv_r});
  assign div_rem  = div_ge ? (div_sh - {1'b0, dv_r}) : div_sh;
  assign sq_trial = rt_r + bit_r;
  assign sq_ge    = (x_r >= sq_trial);
  assign mag_bit  = (cnt_r < 7'd16) ? a_w[4'd15 - cnt_r[3:0]] : 1'b0;
  assign mag_sh   = {mr_r, mag_bit};
  assign mag_ge   = (mag_sh >= {2'b0, ff_r});
  assign mag_sub  = mag_ge ? (mag_sh - {2'b0, ff_r}) : mag_sh;
  assign mq_sh    = {mq_r[47:0], mag_ge};
  assign msat_w   = msat_r | mq_r[48];
  assign mag_val  = msat_w ? M_CAP : mq_sh;
  assign m_abs    = m_r[49] ? (~m_r + 50'd1) : m_r;
  assign opa      = (stg_r == 2'd0) ? {15'd0, m_abs[48:0]} : w_r;
  assign mul_a    = pp_r[1] ? opa[63:32] : opa[31:0];
  assign mul_b    = pp_r[0] ? c_r[63:32] : c_r[31:0];
  assign prod     = mul_a * mul_b;
  assign pp_term  = (pp_r == 2'd0) ? {64'd0, prod} :
                    (pp_r == 2'd3) ? {prod, 64'd0} : {32'd0, prod, 32'd0};
  assign rs_sat   = (stg_r == 2'd0) ? (|p_r[127:112]) : (|p_r[127:96]);
  assign rs_val   = rs_sat ? {64{1'b1}} :
                    ((stg_r == 2'd0) ? p_r[111:48] : p_r[95:32]);
  assign sum65    = {1'b0, c_r} + {1'b0, w_r};
  assign nx_pos   = sum65[64] ? {64{1'b1}} : sum65[63:0];
  assign nx_neg   = (w_r >= c_r) ? 64'd0 : (c_r - w_r);
  assign tq_w     = {32'd0, tgt_r, 16'd0};
  assign tick_clamp = ((nx_r > c_r) && (nx_r > tq_w)) || ((nx_r < c_r) && (nx_r < tq_w));
  assign tick_nx  = tick_clamp ? tq_w : nx_r;
  assign ab_w     = a_w * bb_r;
  assign num_w    = TIMER_BASE_HZ * base_r;
  assign rad_w    = dir_r ? ({2'b0, ff_r} + {1'b0, ta_r}) : ({2'b0, ff_r} - {1'b0, ta_r});
  assign q_tgt    = x_r[31:0];
  assign t16      = (q_tgt == 32'd0) ? 16'd1 : q_tgt[15:0];
  assign stop_spm = {1'b0, cfg.max_iv} + STOP_PAD;
  assign sh_sel   = (cfg.shift[ch_r] > SHIFT_MAX) ? SHIFT_MAX : cfg.shift[ch_r];

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    res_nxt       = res_r;
    cur_nxt       = cur_r;
    tst_nxt       = tst_r;
    ex_nxt        = ex_r;
    rc_nxt        = rc_r;
    ch_nxt        = ch_r;
    op_nxt        = op_r;
    spm_nxt       = spm_r;
    dir_nxt       = dir_r;
    tgt_nxt       = tgt_r;
    sh_nxt        = sh_r;
    base_nxt      = base_r;
    ff_nxt        = ff_r;
    bb_nxt        = bb_r;
    ta_nxt        = ta_r;
    x_nxt         = x_r;
    rem_nxt       = rem_r;
    dv_nxt        = dv_r;
    rt_nxt        = rt_r;
    bit_nxt       = bit_r;
    cnt_nxt       = cnt_r;
    mr_nxt        = mr_r;
    mq_nxt        = mq_r;
    msat_nxt      = msat_r;
    m_nxt         = m_r;
    n_nxt         = n_r;
    c_nxt         = c_r;
    w_nxt         = w_r;
    p_nxt         = p_r;
    pp_nxt        = pp_r;
    stg_nxt       = stg_r;
    ret_tick_nxt  = ret_tick_r;
    nx_nxt        = nx_r;
    q_pop         = 1'b0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (q_valid && (!out_valid_r || !out_stall)) begin
          q_pop     = 1'b1;
          ch_nxt    = q_item.ch;
          op_nxt    = q_item.op;
          spm_nxt   = q_item.spm;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        unique case (op_r)
          OP_DISABLE: begin
            cur_nxt[ch_r] = 16'd0;
            tst_nxt[ch_r] = 16'd0;
            res_nxt       = make_res(ch_r, 1'b0, 16'd0, 1'b1, 1'b0, 1'b1);
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end
          OP_TICK: begin
            if (cur_r[ch_r] == tst_r[ch_r]) begin
              res_nxt       = make_res(ch_r, 1'b0, 16'd0, 1'b0, 1'b0, 1'b1);
              out_valid_nxt = 1'b1;
              state_nxt     = S_IDLE;
            end else begin
              c_nxt        = {32'd0, ex_r[ch_r]};
              m_nxt        = rc_r[ch_r];
              tgt_nxt      = tst_r[ch_r];
              stg_nxt      = 2'd0;
              pp_nxt       = 2'd0;
              p_nxt        = '0;
              ret_tick_nxt = 1'b1;
              state_nxt    = S_RSMUL;
            end
          end
          OP_SPEED: begin
            if (spm_r == 32'd0 && cur_r[ch_r] == 16'd0) begin
              res_nxt       = make_res(ch_r, 1'b0, 16'd0, 1'b0, 1'b1, 1'b1);
              out_valid_nxt = 1'b1;
              state_nxt     = S_IDLE;
            end else begin
              dv_nxt    = (spm_r == 32'd0) ? {15'd0, stop_spm} : spm_r;
              x_nxt     = {TGT_NUM, 32'd0};
              rem_nxt   = '0;
              cnt_nxt   = '0;
              state_nxt = S_TDIV;
            end
          end
          default: begin
            res_nxt       = make_res(ch_r, 1'b0, 16'd0, 1'b0, 1'b0, 1'b0);
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end
        endcase
      end
      S_TDIV: begin
        rem_nxt = div_rem;
        x_nxt   = {x_r[62:0], div_ge};
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r == 7'd31) begin
          state_nxt = S_TGT;
        end
      end
      S_TGT: begin
        tgt_nxt  = t16;
        sh_nxt   = sh_sel;
        base_nxt = (cur_r[ch_r] != 16'd0) ? cur_r[ch_r] :
                   ((cfg.max_iv != 16'd0) ? cfg.max_iv : 16'd1);
        state_nxt = S_FF;
        if (q_tgt > 32'h0000FFFF) begin
          res_nxt       = make_res(ch_r, 1'b0, 16'd0, 1'b0, 1'b0, 1'b0);
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else if (cur_r[ch_r] > t16 || cur_r[ch_r] == 16'd0) begin
          dir_nxt = 1'b1;
          if (t16 > cfg.max_iv) begin
            res_nxt       = make_res(ch_r, 1'b0, 16'd0, 1'b0, 1'b0, 1'b0);
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end
        end else if (cur_r[ch_r] < t16) begin
          dir_nxt = 1'b0;
        end else begin
          res_nxt       = make_res(ch_r, 1'b0, 16'd0, 1'b0, 1'b0, 1'b1);
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_FF: begin
        ff_nxt    = f_w * f_w;
        bb_nxt    = base_r * base_r;
        state_nxt = S_TA;
      end
      S_TA: begin
        ta_nxt    = {ab_w, 1'b0};
        state_nxt = S_RAD;
      end
      S_RAD: begin
        if (!dir_r && ({1'b0, ff_r} <= ta_r)) begin
          res_nxt       = make_res(ch_r, 1'b0, 16'd0, 1'b0, 1'b0, 1'b0);
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          x_nxt     = {6'd0, rad_w, 8'd0};
          rt_nxt    = '0;
          bit_nxt   = 64'd1 << 62;
          state_nxt = S_SQRT;
        end
      end
      S_SQRT: begin
        if (sq_ge) begin
          x_nxt  = x_r - sq_trial;
          rt_nxt = (rt_r >> 1) + bit_r;
        end else begin
          rt_nxt = rt_r >> 1;
        end
        bit_nxt = bit_r >> 2;
        if (bit_r[0]) begin
          state_nxt = S_NUM;
        end
      end
      S_NUM: begin
        dv_nxt    = rt_r[31:0];
        x_nxt     = {4'd0, num_w, 20'd0};
        rem_nxt   = '0;
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        rem_nxt = div_rem;
        x_nxt   = {x_r[62:0], div_ge};
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r == 7'd63) begin
          mr_nxt    = '0;
          mq_nxt    = '0;
          msat_nxt  = 1'b0;
          cnt_nxt   = '0;
          state_nxt = S_MAG;
        end
      end
      S_MAG: begin
        // long division of acc * 2^80 by f^2, sticky on overflow
        mr_nxt   = mag_sub[48:0];
        mq_nxt   = mq_sh;
        msat_nxt = msat_w;
        cnt_nxt  = cnt_r + 7'd1;
        if (cnt_r == 7'd95) begin
          m_nxt     = dir_r ? (~{1'b0, mag_val} + 50'd1) : {1'b0, mag_val};
          c_nxt     = x_r;
          n_nxt     = '0;
          state_nxt = S_RUNCHK;
        end
      end
      S_RUNCHK: begin
        if (c_r > {32'd0, RUNIN_EDGE}) begin
          if (!dir_r || n_r >= RUNIN_LIMIT) begin
            res_nxt       = make_res(ch_r, 1'b0, 16'd0, 1'b0, 1'b0, 1'b0);
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end else begin
            stg_nxt      = 2'd0;
            pp_nxt       = 2'd0;
            p_nxt        = '0;
            ret_tick_nxt = 1'b0;
            state_nxt    = S_RSMUL;
          end
        end else begin
          state_nxt = S_COMMIT;
        end
      end
      S_RSMUL: begin
        p_nxt  = p_r + pp_term;
        pp_nxt = pp_r + 2'd1;
        if (pp_r == 2'd3) begin
          state_nxt = S_RSSH;
        end
      end
      S_RSSH: begin
        w_nxt  = rs_val;
        p_nxt  = '0;
        pp_nxt = 2'd0;
        if (stg_r == 2'd2) begin
          state_nxt = S_RSFIN;
        end else begin
          stg_nxt   = stg_r + 2'd1;
          state_nxt = S_RSMUL;
        end
      end
      S_RSFIN: begin
        nx_nxt    = m_r[49] ? nx_neg : nx_pos;
        state_nxt = ret_tick_r ? S_TICKFIN : S_RUNFIN;
      end
      S_RUNFIN: begin
        if (nx_r == c_r) begin
          res_nxt       = make_res(ch_r, 1'b0, 16'd0, 1'b0, 1'b0, 1'b0);
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          if (nx_r < tq_w) begin
            c_nxt = tq_w;
            m_nxt = '0;
          end else begin
            c_nxt = nx_r;
          end
          n_nxt     = n_r + 11'd1;
          state_nxt = S_RUNCHK;
        end
      end
      S_TICKFIN: begin
        if (tick_clamp) begin
          rc_nxt[ch_r] = '0;
        end
        ex_nxt[ch_r]  = tick_nx[31:0];
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
        if (tick_nx > {32'd0, cfg.max_iv, 16'd0}) begin
          cur_nxt[ch_r] = 16'd0;
          tst_nxt[ch_r] = 16'd0;
          res_nxt       = make_res(ch_r, 1'b0, 16'd0, 1'b1, 1'b1, 1'b1);
        end else begin
          cur_nxt[ch_r] = tick_nx[31:16];
          res_nxt       = make_res(ch_r, 1'b1, tick_nx[31:16], 1'b0, 1'b0, 1'b1);
        end
      end
      S_COMMIT: begin
        tst_nxt[ch_r] = tgt_r;
        rc_nxt[ch_r]  = m_r;
        ex_nxt[ch_r]  = c_r[31:0];
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
        if (c_r[31:16] != 16'hFFFF) begin
          cur_nxt[ch_r] = c_r[31:16];
          res_nxt       = make_res(ch_r, 1'b1, c_r[31:16], 1'b0, 1'b0, 1'b1);
        end else begin
          res_nxt       = make_res(ch_r, 1'b0, 16'd0, 1'b0, 1'b0, 1'b0);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        cur_r[i] <= '0;
        tst_r[i] <= '0;
        ex_r[i]  <= '0;
        rc_r[i]  <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cur_r       <= cur_nxt;
      tst_r       <= tst_nxt;
      ex_r        <= ex_nxt;
      rc_r        <= rc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r      <= res_nxt;
    ch_r       <= ch_nxt;
    op_r       <= op_nxt;
    spm_r      <= spm_nxt;
    dir_r      <= dir_nxt;
    tgt_r      <= tgt_nxt;
    sh_r       <= sh_nxt;
    base_r     <= base_nxt;
    ff_r       <= ff_nxt;
    bb_r       <= bb_nxt;
    ta_r       <= ta_nxt;
    x_r        <= x_nxt;
    rem_r      <= rem_nxt;
    dv_r       <= dv_nxt;
    rt_r       <= rt_nxt;
    bit_r      <= bit_nxt;
    cnt_r      <= cnt_nxt;
    mr_r       <= mr_nxt;
    mq_r       <= mq_nxt;
    msat_r     <= msat_nxt;
    m_r        <= m_nxt;
    n_r        <= n_nxt;
    c_r        <= c_nxt;
    w_r        <= w_nxt;
    p_r        <= p_nxt;
    pp_r       <= pp_nxt;
    stg_r      <= stg_nxt;
    ret_tick_r <= ret_tick_nxt;
    nx_r       <= nx_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = res_r;

  `SRIG_ASSERT_IMP(a_load_not_stop, out_valid_r && res_r.ld, !res_r.stp,
                   "timer load and stop in one result")
  `SRIG_ASSERT_IMP(a_compare_half, out_valid_r, res_r.compare == res_r.period[15:1],
                   "compare is not half the period")
  `SRIG_ASSERT_NXT(a_pop_starts, q_pop, state_r == S_DISP && out_valid_r == 1'b0,
                   "request popped without a free result slot")

endmodule

/* rtl/stepper_ramp_interval_generator.sv */
`timescale 1ns / 1ps
// Four-channel stepper ramp generator. Each request (speed command, step tick
// or disable) yields exactly one result with the channel's new timer period,
// compare value and load/stop/stopped flags. Requests enter a two-deep queue
// and are worked one at a time by a sequencer built around one 32x32
// multiplier and a shared bit-serial divider/square-root unit. A step tick
// is worked as four partial products for each of three products. A speed
// command runs the target divide, the square root, the first-interval divide
// and the ramp constant, in that order; when the first interval needs run-in,
// up to 1024 run-in steps follow, each with the same products as a tick.
// Configuration writes are always ready and must be made while no request is
// outstanding. No clearing pass is needed after reset.
module stepper_ramp_interval_generator
  import srig_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [1:0]      in_mode,
  input  logic [CH_W-1:0] in_channel,
  input  logic [31:0]     in_steps_per_minute,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [CH_W-1:0] out_channel,
  output logic [15:0]     out_period,
  output logic [14:0]     out_compare,
  output logic            out_load_timer,
  output logic            out_stop_timer,
  output logic            out_stopped_event,
  output logic            out_accepted,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [2:0]      cfg_index,
  input  logic [15:0]     cfg_data
);

  cfg_t  cfg_r, cfg_nxt;
  logic  q_full, q_push, q_pop, q_valid;
  item_t push_item, q_item;
  res_t  res;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_SHIFT0: cfg_nxt.shift[0] = cfg_data[2:0];
        CFG_SHIFT1: cfg_nxt.shift[1] = cfg_data[2:0];
        CFG_SHIFT2: cfg_nxt.shift[2] = cfg_data[2:0];
        CFG_SHIFT3: cfg_nxt.shift[3] = cfg_data[2:0];
        CFG_ACCEL:  cfg_nxt.accel    = cfg_data;
        CFG_MAXIV:  cfg_nxt.max_iv   = cfg_data;
        default:    cfg_nxt          = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.shift  <= '0;
      cfg_r.accel  <= 16'd2000;
      cfg_r.max_iv <= 16'd20000;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  srig_front u_front (
    .in_valid            (in_valid),
    .in_mode             (in_mode),
    .in_channel          (in_channel),
    .in_steps_per_minute (in_steps_per_minute),
    .in_stall            (in_stall),
    .q_full              (q_full),
    .q_push              (q_push),
    .q_item              (push_item)
  );

  srig_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .q_valid   (q_valid),
    .q_item    (q_item)
  );

  srig_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (res)
  );

  assign out_channel       = res.ch;
  assign out_period        = res.period;
  assign out_compare       = res.compare;
  assign out_load_timer    = res.ld;
  assign out_stop_timer    = res.stp;
  assign out_stopped_event = res.stopped_ev;
  assign out_accepted      = res.ok;

endmodule

/* tb/stepper_ramp_interval_generator_tb.sv */
`timescale 1ns / 1ps
module stepper_ramp_interval_generator_tb;
  import srig_pkg::*;

  typedef struct {
    logic [1:0]  mode;
    logic [1:0]  ch;
    logic [31:0] spm;
  } motor_cmd_t;

  typedef struct {
    logic [1:0]  ch;
    logic [15:0] period;
    logic [14:0] compare;
    logic        load;
    logic        stop;
    logic        stopped;
    logic        ok;
  } timer_upd_t;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_valid = 1'b0;
  logic            in_stall;
  logic [1:0]      in_mode = '0;
  logic [CH_W-1:0] in_channel = '0;
  logic [31:0]     in_steps_per_minute = '0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  logic [CH_W-1:0] out_channel;
  logic [15:0]     out_period;
  logic [14:0]     out_compare;
  logic            out_load_timer;
  logic            out_stop_timer;
  logic            out_stopped_event;
  logic            out_accepted;
  logic            cfg_valid = 1'b0;
  logic            cfg_ready;
  logic [2:0]      cfg_index = '0;
  logic [15:0]     cfg_data = '0;

  stepper_ramp_interval_generator dut (.*);

  always #10 clk = ~clk;

  // shadow configuration and per-channel ramp state
  logic [2:0]  sh_shift [4];
  logic [15:0] sh_accel;
  logic [15:0] sh_max_iv;
  logic [15:0] cur_period [4];
  logic [15:0] tgt_period [4];
  logic [63:0] exact_q16 [4];
  longint      ramp_m [4];

  motor_cmd_t  cmd_q [$];
  timer_upd_t  upd_q [$];
  int          mismatches = 0;
  logic        calm = 1'b0;

  function automatic logic [63:0] mul_shift(logic [63:0] a, logic [63:0] b, int sh);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    p = p >> sh;
    if (p[127:64] != 0) return '1;
    return p[63:0];
  endfunction

  function automatic logic [63:0] isqrt(logic [63:0] x);
    logic [63:0] r;
    logic [63:0] bitv;
    r = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= r + bitv) begin
        x = x - (r + bitv);
        r = (r >> 1) + bitv;
      end else begin
        r = r >> 1;
      end
      bitv = bitv >> 2;
    end
    return r;
  endfunction

  function automatic logic [63:0] ramp_advance(logic [63:0] c, longint m);
    logic [63:0] mag;
    logic [63:0] w;
    mag = (m < 0) ? 64'(-m) : 64'(m);
    w = mul_shift(mul_shift(mul_shift(mag, c, 48), c, 32), c, 32);
    if (m < 0) return (w >= c) ? 64'd0 : c - w;
    return (w > ~c) ? '1 : c + w;
  endfunction

  function automatic logic [63:0] ramp_mag(logic [63:0] a, logic [63:0] d);
    logic [127:0] q;
    q = ({64'd0, a} << 80) / {64'd0, d};
    if (q > {79'd0, M_CAP}) return {15'd0, M_CAP};
    return q[63:0];
  endfunction

  function automatic void set_load(ref timer_upd_t u, input logic [15:0] p);
    u.period = p;
    u.compare = p[15:1];
    u.load = 1'b1;
  endfunction

  function automatic void speed_update(ref timer_upd_t u, input logic [1:0] ch,
                                       input logic [63:0] spm);
    logic [63:0] tgt, f, a, ff, ta, rad, first, mag, tq, nx, base;
    logic [2:0]  sh;
    int          dir, n;
    longint      m;
    if (spm == 0) begin
      if (cur_period[ch] == 0) begin
        u.stopped = 1'b1;
        u.ok = 1'b1;
        return;
      end
      spm = 64'(sh_max_iv) + 64'(STOP_PAD);
    end
    tgt = 64'(TGT_NUM) / spm;
    if (tgt > 64'hFFFF) return;
    if (tgt == 0) tgt = 1;
    if (cur_period[ch] > tgt || cur_period[ch] == 0) begin
      dir = 1;
      if (tgt > sh_max_iv) return;
    end else if (cur_period[ch] < tgt) begin
      dir = -1;
    end else begin
      u.ok = 1'b1;
      return;
    end
    sh = (sh_shift[ch] > SHIFT_MAX) ? SHIFT_MAX : sh_shift[ch];
    f = 64'(TIMER_BASE_HZ) >> sh;
    a = 64'(sh_accel) >> sh;
    base = cur_period[ch] != 0 ? 64'(cur_period[ch]) :
           (sh_max_iv != 0 ? 64'(sh_max_iv) : 64'd1);
    ff = f * f;
    ta = 2 * a * base * base;
    if (dir > 0) begin
      rad = ff + ta;
    end else begin
      if (ff <= ta) return;
      rad = ff - ta;
    end
    first = ((64'(TIMER_BASE_HZ) * base) << 20) / isqrt(rad << 8);
    mag = ramp_mag(a, ff);
    m = (dir > 0) ? -longint'(mag) : longint'(mag);
    if (first > 64'(RUNIN_EDGE)) begin
      if (dir < 0) return;
      n = 0;
      tq = tgt << 16;
      while (first > 64'(RUNIN_EDGE)) begin
        if (n >= RUNIN_LIMIT) return;
        nx = ramp_advance(first, m);
        if (nx == first) return;
        if (nx < tq) begin
          nx = tq;
          m = 0;
        end
        first = nx;
        n++;
      end
    end
    tgt_period[ch] = tgt[15:0];
    ramp_m[ch] = m;
    exact_q16[ch] = first;
    if ((first >> 16) < 64'hFFFF) begin
      cur_period[ch] = first[31:16];
      set_load(u, cur_period[ch]);
      u.ok = 1'b1;
    end
  endfunction

  function automatic void tick_update(ref timer_upd_t u, input logic [1:0] ch);
    logic [63:0] old, nx, tq;
    u.ok = 1'b1;
    if (cur_period[ch] == tgt_period[ch]) return;
    old = exact_q16[ch];
    nx = ramp_advance(old, ramp_m[ch]);
    tq = 64'(tgt_period[ch]) << 16;
    if ((nx > old && nx > tq) || (nx < old && nx < tq)) begin
      nx = tq;
      ramp_m[ch] = 0;
    end
    exact_q16[ch] = {32'd0, nx[31:0]};
    cur_period[ch] = nx[31:16];
    if (nx > (64'(sh_max_iv) << 16)) begin
      cur_period[ch] = 0;
      tgt_period[ch] = 0;
      u.stop = 1'b1;
      u.stopped = 1'b1;
    end else begin
      set_load(u, cur_period[ch]);
    end
  endfunction

  function automatic timer_upd_t predict_update(motor_cmd_t c);
    timer_upd_t u;
    u = '{ch: c.ch, period: '0, compare: '0, load: 0, stop: 0, stopped: 0, ok: 0};
    if (int'(c.ch) >= CHANNELS) return u;
    case (c.mode)
      MODE_SPEED: speed_update(u, c.ch, 64'(c.spm));
      MODE_TICK: tick_update(u, c.ch);
      MODE_DISABLE: begin
        cur_period[c.ch] = 0;
        tgt_period[c.ch] = 0;
        u.stop = 1'b1;
        u.ok = 1'b1;
      end
      default: ;
    endcase
    return u;
  endfunction

  // driver: hold a stalled request, advance on acceptance
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) upd_q.push_back(predict_update(cmd_q.pop_front()));
      if (!in_valid || !in_stall) begin
        if (cmd_q.size() > 0 && (calm || $urandom_range(0, 99) >= 28)) begin
          in_valid <= 1'b1;
          in_mode <= cmd_q[0].mode;
          in_channel <= cmd_q[0].ch;
          in_steps_per_minute <= cmd_q[0].spm;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    timer_upd_t e;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (upd_q.size() == 0) begin
          $error("result with no pending request, channel %0d", out_channel);
          mismatches++;
        end else begin
          e = upd_q.pop_front();
          if (out_channel !== e.ch) begin
            $error("out_channel expected %0d got %0d", e.ch, out_channel);
            mismatches++;
          end
          if (out_period !== e.period) begin
            $error("period expected %0d got %0d", e.period, out_period);
            mismatches++;
          end
          if (out_compare !== e.compare) begin
            $error("compare expected %0d got %0d", e.compare, out_compare);
            mismatches++;
          end
          if (out_load_timer !== e.load) begin
            $error("load_timer expected %0d got %0d", e.load, out_load_timer);
            mismatches++;
          end
          if (out_stop_timer !== e.stop) begin
            $error("stop_timer expected %0d got %0d", e.stop, out_stop_timer);
            mismatches++;
          end
          if (out_stopped_event !== e.stopped) begin
            $error("stopped_event expected %0d got %0d", e.stopped, out_stopped_event);
            mismatches++;
          end
          if (out_accepted !== e.ok) begin
            $error("accepted expected %0d got %0d", e.ok, out_accepted);
            mismatches++;
          end
        end
      end
      out_stall <= !calm && $urandom_range(0, 99) < 28;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx <= CFG_SHIFT3) sh_shift[idx] = val[2:0];
    else if (idx == CFG_ACCEL) sh_accel = val;
    else if (idx == CFG_MAXIV) sh_max_iv = val;
  endtask

  task automatic configure(logic [2:0] s0, logic [2:0] s1, logic [2:0] s2, logic [2:0] s3,
                           logic [15:0] acc, logic [15:0] miv);
    write_reg(CFG_SHIFT0, 16'(s0));
    write_reg(CFG_SHIFT1, 16'(s1));
    write_reg(CFG_SHIFT2, 16'(s2));
    write_reg(CFG_SHIFT3, 16'(s3));
    write_reg(CFG_ACCEL, acc);
    write_reg(CFG_MAXIV, miv);
  endtask

  task automatic push_cmd(logic [1:0] mode, logic [1:0] ch, logic [31:0] spm);
    cmd_q.push_back('{mode: mode, ch: ch, spm: spm});
  endtask

  task automatic drain();
    while (cmd_q.size() > 0 || in_valid || upd_q.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic random_traffic(int count);
    int          n, r, k;
    logic [1:0]  ch;
    logic [31:0] iv;
    n = 0;
    while (n < count) begin
      ch = 2'($urandom_range(0, 3));
      r = $urandom_range(0, 99);
      if (r < 55) begin
        iv = $urandom_range(1, (sh_max_iv > 2) ? sh_max_iv + 2 : 3);
        push_cmd(MODE_SPEED, ch, TGT_NUM / iv);
      end else if (r < 65) begin
        push_cmd(MODE_SPEED, ch, 32'd0);
      end else if (r < 71) begin
        push_cmd(MODE_DISABLE, ch, $urandom);
      end else if (r < 75) begin
        push_cmd(2'(OP_NOP), ch, $urandom);
      end else if (r < 85) begin
        push_cmd(MODE_SPEED, ch, $urandom);
      end
      n++;
      k = $urandom_range(3, 40);
      repeat (k) begin
        if ($urandom_range(0, 9) == 0) push_cmd(MODE_TICK, 2'($urandom_range(0, 3)), $urandom);
        else push_cmd(MODE_TICK, ch, $urandom);
      end
      n += k;
    end
  endtask

  initial begin
    sh_shift = '{default: '0};
    sh_accel = 16'd2000;
    sh_max_iv = 16'd20000;
    cur_period = '{default: '0};
    tgt_period = '{default: '0};
    exact_q16 = '{default: '0};
    ramp_m = '{default: 0};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    configure(3'd0, 3'd0, 3'd0, 3'd0, 16'd2000, 16'd20000);
    // directed: stop while stopped, limits of target, decel, stop, disable
    push_cmd(MODE_SPEED, 2'd0, 32'd0);
    push_cmd(MODE_SPEED, 2'd0, 32'd100);
    push_cmd(MODE_SPEED, 2'd0, 32'd30000);
    push_cmd(MODE_SPEED, 2'd0, 32'd36000);
    push_cmd(MODE_TICK, 2'd0, 32'hFFFFFFFF);
    push_cmd(MODE_SPEED, 2'd1, 32'hFFFFFFFF);
    push_cmd(MODE_SPEED, 2'd2, 32'd720000000);
    push_cmd(MODE_TICK, 2'd1, 32'd0);
    push_cmd(MODE_TICK, 2'd1, 32'd0);
    push_cmd(MODE_SPEED, 2'd3, 32'd7200000);
    push_cmd(MODE_TICK, 2'd3, 32'd0);
    push_cmd(MODE_TICK, 2'd3, 32'd0);
    push_cmd(MODE_SPEED, 2'd3, 32'd72000);
    push_cmd(MODE_TICK, 2'd3, 32'd0);
    push_cmd(MODE_SPEED, 2'd3, 32'd0);
    push_cmd(MODE_TICK, 2'd3, 32'd0);
    push_cmd(MODE_TICK, 2'd3, 32'd0);
    push_cmd(2'(OP_NOP), 2'd2, 32'hFFFFFFFF);
    push_cmd(MODE_DISABLE, 2'd2, 32'd0);
    push_cmd(MODE_TICK, 2'd2, 32'd0);
    push_cmd(MODE_SPEED, 2'd2, 32'd0);
    random_traffic(300);
    drain();

    configure(3'd5, 3'd7, 3'd1, 3'd3, 16'd65535, 16'd65535);
    calm = 1'b1;
    random_traffic(320);
    drain();
    calm = 1'b0;

    configure(3'd0, 3'd2, 3'd4, 3'd6, 16'd1, 16'd1);
    random_traffic(200);
    drain();

    configure(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
              3'($urandom_range(0, 7)), 16'($urandom_range(1, 65535)),
              16'($urandom_range(100, 65535)));
    random_traffic(320);
    drain();

    configure(3'd1, 3'd0, 3'd5, 3'd2, 16'd30000, 16'd300);
    random_traffic(450);
    drain();
    repeat (300) @(posedge clk);

    if (mismatches == 0 && upd_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #4s;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/srig_pkg.sv
rtl/srig_front.sv
rtl/srig_queue.sv
rtl/srig_back.sv
rtl/stepper_ramp_interval_generator.sv
tb/stepper_ramp_interval_generator_tb.sv
